// ===== sv/slfr_pkg.sv =====
package slfr_pkg;
  localparam int LongLag = 55;
  localparam int ShortLag = 21;
  localparam int MixOffset = 30;
  localparam int MixPasses = 4;
  localparam logic [31:0] Mseed = 32'd161803398;
  localparam logic [31:0] Mbig = 32'h7FFF_FFFF;
  localparam logic [31:0] WideDiv = 32'hFFFF_FFFD;
  localparam logic [31:0] WideBias = 32'h7FFF_FFFE;

  typedef enum logic [1:0] {
    OpSeed = 2'd0,
    OpRaw = 2'd1,
    OpBounded = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle, StLoad, StMix, StFinal, StDraw1, StDraw2, StMul, StDiv, StOut
  } state_e;

  typedef struct packed {
    logic        shift;
    logic        load;
    logic [31:0] load_word;
  } ring_ctl_t;

  function automatic logic [31:0] fold(input logic [31:0] x);
    fold = x[31] ? x + Mbig : x;
  endfunction
endpackage

// ===== sv/slfr_cell.sv =====
module slfr_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] d_i,
  output logic [31:0] q_o
);
  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;
endmodule

// ===== sv/slfr_ring.sv =====
module slfr_ring
  import slfr_pkg::*;
(
  input  logic                clk_i,
  input  slfr_pkg::ring_ctl_t ctl_i,
  output logic [31:0]         head_o,
  output logic [31:0]         tap_o,
  output logic [31:0]         mix_o
);
  logic [31:0] word [LongLag];

  for (genvar g = 0; g < LongLag; g++) begin : g_cell
    logic [31:0] d;
    if (g == LongLag - 1) begin : g_tail
      assign d = ctl_i.load ? ctl_i.load_word : word[0];
    end else begin : g_body
      assign d = word[g + 1];
    end
    slfr_cell u_cell (
      .clk_i(clk_i),
      .en_i (ctl_i.shift),
      .d_i  (d),
      .q_o  (word[g])
    );
  end

  assign head_o = word[0];
  assign tap_o  = word[ShortLag];
  assign mix_o  = word[MixOffset + 1];
endmodule

// ===== sv/slfr_divider.sv =====
module slfr_divider
  import slfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        wide_i,
  input  logic [63:0] num_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [2:0]  stage_q;
  logic        wide_q;
  logic [63:0] num_q;
  logic [31:0] q0_q, quot_q;
  logic [33:0] r0_q, r1_q;
  logic [31:0] q0_d;
  logic [33:0] r0_d, r1_d;
  logic [2:0]  q1;
  logic        round_up;

  // The divisor is 2^k - c, so 2^k folds back as c.
  always_comb begin
    if (wide_q) begin
      q0_d = num_q[63:32];
      r0_d = {2'b00, num_q[31:0]} + {2'b00, q0_d} + {1'b0, q0_d, 1'b0};
      q1   = {1'b0, r0_q[33:32]};
      r1_d = {2'b00, r0_q[31:0]} + {31'd0, q1} + {30'd0, q1, 1'b0};
    end else begin
      q0_d = num_q[62:31];
      r0_d = {3'b000, num_q[30:0]} + {2'b00, q0_d};
      q1   = r0_q[33:31];
      r1_d = {3'b000, r0_q[30:0]} + {31'd0, q1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      wide_q <= wide_i;
    end
    if (stage_q[0]) begin
      q0_q <= q0_d;
      r0_q <= r0_d;
    end
    if (stage_q[1]) begin
      quot_q <= q0_q + {29'd0, q1};
      r1_q   <= r1_d;
    end
  end

  assign round_up = wide_q ? (r1_q >= {2'b00, WideDiv}) : (r1_q >= {2'b00, Mbig});
  assign done_o   = stage_q[2];
  assign quot_o   = quot_q + {31'd0, round_up};
endmodule

// ===== sv/subtractive_lagged_fibonacci_rng.sv =====
// Subtractive lagged-Fibonacci generator with a 55-word table held in a
// shifting ring of cells, so the read word is always at the head and the
// tap word sits a fixed distance behind it.
// Raise start with operation_i and the operands while busy is low; the
// transaction is taken on that edge and busy rises on the next cycle,
// except for OpNone, which leaves busy low. A raw sample shows on value_o
// with valid_o high for one cycle. A bounded sample takes one draw, or two
// for a range above 2^31-1, then a multiply and a three-step division by a
// constant; an inverted range skips the draws and the division. One
// transaction is in flight.
// A seed transaction gives no result. It writes the table words one at a
// time while the ring turns, so that each word lands in table order, then
// runs 220 mixing steps and one idle step.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset clears the control state; the table stays undefined until seeded.
module subtractive_lagged_fibonacci_rng
  import slfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic signed [31:0] seed_value_i,
  input  logic signed [31:0] min_value_i,
  input  logic signed [31:0] max_value_i,
  output logic        valid_o,
  output logic signed [31:0] value_o
);
  state_e state_q, state_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [4:0]  ph_q, ph_d;
  logic [31:0] mj_q, mj_d, mk_q, mk_d;
  logic [31:0] s_q, s_d;
  logic        t_q, t_d;
  logic [31:0] min_q;
  logic [32:0] range_q;
  logic [1:0]  op_q;
  logic        wide_q;
  logic [31:0] res_q, res_d;
  logic        valid_q, valid_d;
  ring_ctl_t   ctl;
  logic [31:0] head, tap, mix, draw_v;
  logic        div_start, div_done;
  logic [63:0] div_num;
  logic [31:0] div_q;
  logic [32:0] range_c;
  logic [31:0] seed_mag;
  logic [32:0] s_ext, s_mag, n_wide, mul_a;
  logic [63:0] prod;

  slfr_ring u_ring (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .head_o(head),
    .tap_o (tap),
    .mix_o (mix)
  );

  slfr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .wide_i (wide_q),
    .num_i  (div_num),
    .done_o (div_done),
    .quot_o (div_q)
  );

  always_comb begin
    logic [31:0] v;
    v = head - tap;
    if (v == Mbig) begin
      v = v - 32'd1;
    end
    draw_v = fold(v);
  end

  assign range_c  = {max_value_i[31], max_value_i} - {min_value_i[31], min_value_i};
  assign seed_mag = (seed_value_i == 32'sh8000_0000) ? Mbig :
                    (seed_value_i[31] ? 32'(-seed_value_i) : seed_value_i);
  assign s_ext    = {s_q[31], s_q};
  assign s_mag    = s_q[31] ? 33'(-s_ext) : s_ext;
  assign n_wide   = (t_q ? s_ext : 33'(-s_ext)) + {1'b0, WideBias};
  assign mul_a    = wide_q ? n_wide : s_mag;
  assign prod     = {31'd0, mul_a} * {31'd0, range_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ph_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mj_q  <= mj_d;
    mk_q  <= mk_d;
    s_q   <= s_d;
    t_q   <= t_d;
    res_q <= res_d;
    if (start && !busy) begin
      op_q    <= operation_i;
      min_q   <= min_value_i;
      range_q <= range_c;
      wide_q  <= !range_c[32] && (range_c > {1'b0, Mbig});
    end
  end

  always_comb begin
    logic [31:0] q32;
    state_d   = state_q;
    cnt_d     = cnt_q;
    ph_d      = ph_q;
    mj_d      = mj_q;
    mk_d      = mk_q;
    s_d       = s_q;
    t_d       = t_q;
    res_d     = res_q;
    valid_d   = 1'b0;
    ctl       = '0;
    div_start = 1'b0;
    div_num   = prod;
    q32       = div_q;
    case (state_q)
      StIdle: begin
        if (start && !busy) begin
          case (op_e'(operation_i))
            OpSeed: begin
              mj_d    = Mseed - seed_mag;
              mk_d    = 32'd1;
              cnt_d   = '0;
              ph_d    = '0;
              state_d = StLoad;
            end
            OpRaw: state_d = StDraw1;
            OpBounded: begin
              if ($signed(min_value_i) > $signed(max_value_i)) begin
                res_d   = min_value_i;
                state_d = StOut;
              end else begin
                state_d = StDraw1;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StLoad: begin
        // The ring turns every cycle and a word is written whenever ph_q is zero;
        // the phase period equals the stride of the positions the seeding visits.
        ctl.shift = 1'b1;
        if (ph_q == '0) begin
          if (cnt_q == 9'(LongLag)) begin
            cnt_d   = '0;
            state_d = StMix;
          end else begin
            ctl.load = 1'b1;
            cnt_d    = cnt_q + 9'd1;
            if (cnt_q == '0) begin
              ctl.load_word = mj_q;
            end else begin
              ctl.load_word = mk_q;
              mk_d = fold(mj_q - mk_q);
              mj_d = mk_q;
            end
          end
        end
        ph_d = (ph_q == 5'(ShortLag - 1)) ? '0 : ph_q + 5'd1;
      end
      StMix: begin
        ctl.shift = 1'b1;
        ctl.load  = 1'b1;
        ctl.load_word = fold(head - mix);
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'(MixPasses * LongLag - 1)) begin
          cnt_d   = '0;
          state_d = StFinal;
        end
      end
      StFinal: state_d = StIdle;
      StDraw1: begin
        ctl.shift = 1'b1;
        ctl.load  = 1'b1;
        ctl.load_word = draw_v;
        s_d = draw_v;
        if (op_e'(op_q) == OpRaw) begin
          res_d   = draw_v;
          state_d = StOut;
        end else if (wide_q) begin
          state_d = StDraw2;
        end else begin
          state_d = StMul;
        end
      end
      StDraw2: begin
        ctl.shift = 1'b1;
        ctl.load  = 1'b1;
        ctl.load_word = draw_v;
        t_d       = draw_v[0];
        state_d   = StMul;
      end
      StMul: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          if (!wide_q && s_q[31]) begin
            q32 = 32'(-div_q);
          end
          res_d   = min_q + q32;
          state_d = StOut;
        end
      end
      StOut: begin
        valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy    = (state_q != StIdle) || valid_q;
  assign valid_o = valid_q;
  assign value_o = res_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == StOut))
    else $error("result without output state");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i != OpNone) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held");
endmodule

// ===== sim/slfr_checker.sv =====
`timescale 1ns / 100ps
module slfr_checker
  import slfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] seed_value_i,
  input  logic signed [31:0] min_value_i,
  input  logic signed [31:0] max_value_i,
  input  logic               valid_o,
  input  logic signed [31:0] value_o,
  output int                 fail_count_o,
  output int                 pending_o
);
  logic [31:0] lag_words [LongLag];
  int unsigned read_pos;
  int unsigned tap_pos;
  logic [31:0] sample_queue [$];

  function automatic logic [31:0] wrap_pos(input logic [31:0] x);
    return x[31] ? x + Mbig : x;
  endfunction

  task automatic seed_words(input logic [31:0] seed);
    logic [31:0] mag;
    logic [31:0] mj;
    logic [31:0] mk;
    int pos;
    if (seed == 32'h8000_0000) mag = Mbig;
    else if (seed[31]) mag = -seed;
    else mag = seed;
    mj = Mseed - mag;
    lag_words[LongLag - 1] = mj;
    mk = 32'd1;
    for (int i = 1; i < LongLag; i++) begin
      pos = (ShortLag * i) % LongLag;
      lag_words[pos - 1] = mk;
      mk = wrap_pos(mj - mk);
      mj = lag_words[pos - 1];
    end
    for (int k = 0; k < MixPasses; k++) begin
      for (int i = 1; i <= LongLag; i++) begin
        lag_words[i - 1] = wrap_pos(lag_words[i - 1] - lag_words[(i + MixOffset) % LongLag]);
      end
    end
    read_pos = 0;
    tap_pos = ShortLag;
  endtask

  function automatic logic [31:0] next_sample();
    logic [31:0] v;
    read_pos = (read_pos + 1 > LongLag) ? 1 : read_pos + 1;
    tap_pos = (tap_pos + 1 > LongLag) ? 1 : tap_pos + 1;
    v = lag_words[read_pos - 1] - lag_words[tap_pos - 1];
    if (v == Mbig) v = v - 1;
    v = wrap_pos(v);
    lag_words[read_pos - 1] = v;
    return v;
  endfunction

  function automatic logic [31:0] scaled_sample(input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
    longint span;
    longint s;
    longint n;
    logic [31:0] t;
    logic [63:0] q;
    if (lo > hi) return lo;
    span = longint'(hi) - longint'(lo);
    s = longint'($signed(next_sample()));
    if (span <= longint'(Mbig)) begin
      q = (s * span) / longint'(Mbig);
    end else begin
      t = next_sample();
      n = t[0] ? s : -s;
      q = (64'(n + longint'(WideBias)) * 64'(span)) / 64'(WideDiv);
    end
    return lo + q[31:0];
  endfunction

  initial begin
    fail_count_o = 0;
    read_pos = 0;
    tap_pos = ShortLag;
    for (int i = 0; i < LongLag; i++) lag_words[i] = '0;
  end

  assign pending_o = sample_queue.size();

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (valid_o) begin
        if (sample_queue.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("Unexpected result %0d", value_o);
        end else begin
          want = sample_queue.pop_front();
          if (value_o !== want) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display("value mismatch: expected %0d, got %0d", $signed(want), value_o);
          end
        end
      end
      if (start && !busy) begin
        case (op_e'(operation_i))
          OpSeed: seed_words(seed_value_i);
          OpRaw: sample_queue.push_back(next_sample());
          OpBounded: sample_queue.push_back(scaled_sample(min_value_i, max_value_i));
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== sim/subtractive_lagged_fibonacci_rng_test.sv =====
`timescale 1ns / 100ps
module subtractive_lagged_fibonacci_rng_test;
  import slfr_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation_i = OpSeed;
  logic signed [31:0] seed_value_i = '0;
  logic signed [31:0] min_value_i = '0;
  logic signed [31:0] max_value_i = '0;
  logic               valid_o;
  logic signed [31:0] value_o;
  int                 fail_count;
  int                 pending;
  int unsigned        cycle_count = 0;
  int unsigned        gap_left = 0;

  localparam int unsigned CycleLimit = 8_000_000;

  subtractive_lagged_fibonacci_rng u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .operation_i(operation_i), .seed_value_i(seed_value_i),
    .min_value_i(min_value_i), .max_value_i(max_value_i),
    .valid_o(valid_o), .value_o(value_o)
  );

  slfr_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .operation_i(operation_i), .seed_value_i(seed_value_i),
    .min_value_i(min_value_i), .max_value_i(max_value_i),
    .valid_o(valid_o), .value_o(value_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(0, 200) - 100;
      default: return $urandom();
    endcase
  endfunction

  task automatic issue(input op_e op, input logic [31:0] seed, input logic [31:0] lo,
                       input logic [31:0] hi, input bit may_idle);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    if (may_idle && $urandom_range(0, 5) == 0)
      gap_left = $urandom_range(1, 15);
    while (gap_left > 0) begin
      @(negedge clk_i);
      gap_left--;
    end
    start <= 1'b1;
    operation_i <= op;
    seed_value_i <= seed;
    min_value_i <= lo;
    max_value_i <= hi;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned pick;
    op_e op;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(OpSeed, 32'h8000_0000, '0, '0, 1'b0);
    issue(OpRaw, '0, '0, '0, 1'b0);
    issue(OpNone, '0, '0, '0, 1'b0);
    issue(OpBounded, '0, 32'sd10, 32'sd5, 1'b0);
    issue(OpBounded, '0, 32'sd7, 32'sd7, 1'b0);
    issue(OpBounded, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    issue(OpBounded, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    issue(OpBounded, '0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    issue(OpBounded, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    issue(OpBounded, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    issue(OpSeed, 32'h7FFF_FFFF, '0, '0, 1'b0);
    issue(OpRaw, '0, '0, '0, 1'b0);
    issue(OpSeed, 32'h0000_0000, '0, '0, 1'b0);
    issue(OpRaw, '0, '0, '0, 1'b0);
    issue(OpSeed, 32'hFFFF_FFFF, '0, '0, 1'b0);
    issue(OpBounded, '0, 32'sd0, 32'sd1, 1'b0);
    issue(OpBounded, '0, 32'h8000_0000, 32'h0000_0000, 1'b0);

    for (int i = 0; i < 1800; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OpSeed;
      else if (pick < 5) op = OpNone;
      else if (pick < 45) op = OpRaw;
      else op = OpBounded;
      lo = pick_word();
      hi = pick_word();
      if ($urandom_range(0, 3) == 0 && $signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
      issue(op, pick_word(), lo, hi, i < 1600);
    end

    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
